@@ rtl/core/clist_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular list engine package
// Sizes, operation and status codes, memory control bundle and index helpers.
// ----------------------------------------------------------------------------
package clist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;
  localparam int POS_W    = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_FIRST = 3'd1,
    OP_DEL_LAST  = 3'd2,
    OP_DEL_VALUE = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_LIST_ALL  = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FOUND     = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_ctl_t;

  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] base);
    return (base == '0) ? IDX_W'(CAPACITY - 1) : base - IDX_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, v};
    return wide[POS_W-1:0];
  endfunction

endpackage

@@ rtl/core/clist_if.sv @@
// ----------------------------------------------------------------------------
// Circular list engine channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clist_req_if;
  import clist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface clist_rsp_if;
  import clist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] entry_value;
  logic                     last_result;

  modport source (output valid, output status, output position, output entry_value,
                  output last_result, input ready);
  modport sink   (input valid, input status, input position, input entry_value,
                  input last_result, output ready);
endinterface

@@ rtl/core/circular_list_engine.sv @@
// ----------------------------------------------------------------------------
// Circular list engine
// Insert, delete first/last and any request on an empty list: response registered
//   from the S_RESP state once the response register is free; next request taken in idle.
// Search, delete value, list all: walk one stored entry per cycle through the memory
//   read port while the response register is free; next request taken after the
//   last response; list all gives one response a cycle while the response register is free.
// A response stall holds the walk. Synchronous reset empties the list at once.
// ----------------------------------------------------------------------------
module circular_list_engine import clist_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  clist_req_if.sink   req,
  clist_rsp_if.source rsp
);

  ram_ctl_t          ram;
  logic [DATA_W-1:0] rdata;

  clist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .ram   (ram),
    .rdata (rdata)
  );

  clist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

endmodule

@@ rtl/core/clist_ram.sv @@
// ----------------------------------------------------------------------------
// Circular list entry memory
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module clist_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/clist_ctrl.sv @@
// ----------------------------------------------------------------------------
// Circular list sequencer
// Holds head and count, walks the entry memory and drives the response register.
// ----------------------------------------------------------------------------
module clist_ctrl import clist_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  clist_req_if.sink         req,
  clist_rsp_if.source       rsp,
  output ram_ctl_t          ram,
  input  logic [DATA_W-1:0] rdata
);

  typedef enum logic [1:0] {S_IDLE, S_RESP, S_WALK} state_t;

  state_t                   state;
  logic [IDX_W-1:0]         head;
  logic [CNT_W-1:0]         count;
  opcode_t                  op;
  logic [DATA_W-1:0]        val;
  status_t                  res_status;
  logic [CNT_W-1:0]         rd_off;
  logic [CNT_W-1:0]         data_off;
  logic                     pend;
  logic                     matched;
  logic                     out_valid;
  status_t                  out_status;
  logic [POS_W-1:0]         out_pos;
  logic [DATA_W-1:0]        out_value;
  logic                     out_last;

  logic                     accept;
  logic                     out_free;
  logic                     out_load;
  logic                     consume;
  logic                     issue;
  logic                     is_last;
  logic                     hit;
  logic                     full;
  logic                     ins_we;
  logic                     shift_we;
  logic [CNT_W-1:0]         prev_off;
  logic [CNT_W-1:0]         cur_pos;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign full      = (count >= CNT_W'(CAPACITY));
  assign consume   = (state == S_WALK) && pend && out_free;
  assign issue     = (state == S_WALK) && (rd_off < count) && (!pend || consume);
  assign is_last   = (data_off == count - CNT_W'(1));
  assign hit       = (rdata == val);
  assign prev_off  = data_off - CNT_W'(1);
  assign cur_pos   = data_off + CNT_W'(1);
  assign out_load  = ((state == S_RESP) && out_free) ||
                     (consume && (is_last || (op == OP_LIST_ALL) ||
                                  ((op == OP_SEARCH) && hit)));

  assign ins_we   = accept && (opcode_t'(req.opcode) == OP_INSERT) && !full;
  assign shift_we = consume && (op == OP_DEL_VALUE) && matched;

  always_comb begin
    ram.re    = issue;
    ram.raddr = slot_add(head, rd_off[IDX_W-1:0]);
    ram.we    = ins_we || shift_we;
    if (ins_we) begin
      ram.waddr = slot_dec(head);
      ram.wdata = req.value;
    end else begin
      ram.waddr = slot_add(head, prev_off[IDX_W-1:0]);
      ram.wdata = rdata;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.entry_value = out_value;
  assign rsp.last_result = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      matched   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= opcode_t'(req.opcode);
            val <= req.value;
            unique case (opcode_t'(req.opcode))
              OP_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  head       <= slot_dec(head);
                  count      <= count + CNT_W'(1);
                  res_status <= ST_DONE;
                end
                state <= S_RESP;
              end
              OP_DEL_FIRST: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  head       <= slot_add(head, IDX_W'(1));
                  count      <= count - CNT_W'(1);
                  res_status <= ST_DONE;
                end
                state <= S_RESP;
              end
              OP_DEL_LAST: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  count      <= count - CNT_W'(1);
                  res_status <= ST_DONE;
                end
                state <= S_RESP;
              end
              OP_DEL_VALUE, OP_SEARCH, OP_LIST_ALL: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  rd_off  <= '0;
                  pend    <= 1'b0;
                  matched <= 1'b0;
                  state   <= S_WALK;
                end
              end
              default: begin
                // drop unused opcodes
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status <= res_status;
            out_pos    <= '0;
            out_value  <= val;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_WALK: begin
          if (issue) begin
            rd_off   <= rd_off + CNT_W'(1);
            data_off <= rd_off;
            pend     <= 1'b1;
          end else if (consume) begin
            pend <= 1'b0;
          end
          if (consume) begin
            unique case (op)
              OP_SEARCH: begin
                if (hit || is_last) begin
                  out_status <= hit ? ST_FOUND : ST_NOT_FOUND;
                  out_pos    <= hit ? to_pos(cur_pos) : '0;
                  out_value  <= val;
                  out_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end
              OP_DEL_VALUE: begin
                if (!matched && hit) begin
                  matched <= 1'b1;
                end
                if (is_last) begin
                  if (matched || hit) begin
                    count      <= count - CNT_W'(1);
                    out_status <= ST_DONE;
                  end else begin
                    out_status <= ST_NOT_FOUND;
                  end
                  out_pos   <= '0;
                  out_value <= val;
                  out_last  <= 1'b1;
                  state     <= S_IDLE;
                end
              end
              default: begin
                out_status <= ST_LISTED;
                out_pos    <= to_pos(cur_pos);
                out_value  <= rdata;
                out_last   <= is_last;
                if (is_last) begin
                  state <= S_IDLE;
                end
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_partial_is_listing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_LISTED))
    else $error("non-final response outside list-all");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_we |=> (count == $past(count) + CNT_W'(1)) && (head == slot_dec($past(head))))
    else $error("insert did not advance head and count");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram.we |-> ((state == S_IDLE) && accept) || ((state == S_WALK) && matched))
    else $error("entry write outside insert or shift");

endmodule
